// ===== rtl/skeleton_endpoint_detect_top_defines.svh =====
`ifndef SKELETON_ENDPOINT_DETECT_TOP_DEFINES_SVH
`define SKELETON_ENDPOINT_DETECT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sed_pkg.sv =====
package sed_pkg;

  localparam int unsigned MaxWidthDef = 2048;
  localparam int unsigned WidthRst    = 640;
  localparam int unsigned HeightRst   = 480;
  localparam int unsigned RegWidthW   = 12;
  localparam int unsigned RegHeightW  = 13;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 13;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = CfgIdxW'(1);

  typedef struct packed {
    logic endpoint;
    logic center_fg;
    logic frame_end;
  } result_t;

  typedef struct packed {
    logic emit;
    logic clr;
    logic pix;
    logic top_out;
    logic bot_out;
    logic left_out;
    logic right_out;
    logic frame_end;
  } stage_t;

endpackage

// ===== rtl/skeleton_endpoint_detect_top.sv =====
// Endpoint detector for a binary skeleton streamed in raster order, one pixel per transaction.
// One transaction is taken every cycle while in_ready_o is high; the result for a centre pixel
// follows the transaction that completes its 3x3 window, i.e. image_width+1 pixels after the
// centre itself. Throughput is set by the single line memory (two bits per column, one read
// and one write per pixel); a two-entry output queue absorbs stalls on the result side. After
// the last pixel of a frame send image_width+1 flush transactions to drain it. A width or
// height write restarts the frame. The line memory needs no clearing after reset: entries from
// earlier rows or frames always fall on window cells outside the image and are masked.
`include "skeleton_endpoint_detect_top_defines.svh"
module skeleton_endpoint_detect_top import sed_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic                pixel_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                endpoint_o,
  output logic                center_fg_o,
  output logic                frame_end_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 2);
  localparam int unsigned RW = RegHeightW + 1;
  localparam int unsigned WidthRstEff = (WidthRst > MAX_WIDTH) ? MAX_WIDTH : WidthRst;

  logic [WW-1:0]         width_q;
  logic [RegHeightW-1:0] height_q;
  logic [CW-1:0]         col_q, col_d;
  logic [RW-1:0]         row_q, row_d;
  logic [PW-1:0]         pend_q, pend_d;
  logic                  win_clr_q, win_clr_d;

  logic                  s1_valid_q;
  stage_t                s1_q, s1_d;
  logic [CW-1:0]         s1_addr_q;
  logic                  fwd_q, fwd_d;
  logic [1:0]            fwd_data_q;
  logic [1:0]            rd_q;
  logic [8:0]            win_q;
  logic [1:0]            line_mem_q [MAX_WIDTH];

  result_t               fifo_q [2];
  logic                  wp_q, rp_q;
  logic [1:0]            cnt_q;

  logic [RegWidthW-1:0]  wreg;
  logic [WW-1:0]         width_cfg;
  logic [RegHeightW-1:0] height_cfg;
  logic                  cfg_hit;

  logic                  in_acc, pop, push;
  logic [1:0]            occ;
  logic                  restart_pre, flush_ok, do_proc;
  logic [CW-1:0]         c_use, cc;
  logic [RW-1:0]         r_use, cr;
  logic [WW-1:0]         c_inc;
  logic                  wrap, c_pos;
  logic [PW-1:0]         pend_dec;

  logic [1:0]            rd_eff;
  logic                  mid, top;
  logic [8:0]            win_nx, nb;
  logic                  m1, m2, m3, m4;
  result_t               res;

  // configuration
  assign wreg    = cfg_data_i[RegWidthW-1:0];
  assign cfg_hit = cfg_we_i && (cfg_index_i == CFG_IMAGE_WIDTH ||
                                cfg_index_i == CFG_IMAGE_HEIGHT);

  always_comb begin
    if (wreg == '0) begin
      width_cfg = WW'(1);
    end else if (32'(wreg) > MAX_WIDTH) begin
      width_cfg = WW'(MAX_WIDTH);
    end else begin
      width_cfg = WW'(wreg);
    end
    height_cfg = (cfg_data_i == '0) ? RegHeightW'(1) : cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(WidthRstEff);
      height_q <= RegHeightW'(HeightRst);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= width_cfg;
        CFG_IMAGE_HEIGHT: height_q <= height_cfg;
        default: ;
      endcase
    end
  end

  // handshake
  assign pop        = out_valid_o && out_ready_i;
  assign occ        = cnt_q + {1'b0, s1_valid_q};
  assign in_ready_o = (occ < 2'd2) || (occ == 2'd2 && pop);
  assign in_acc     = in_valid_i && in_ready_o;

  // position and window geometry
  assign restart_pre = row_q >= RW'(height_q);
  assign flush_ok    = restart_pre && (pend_q != '0);
  assign do_proc     = in_acc && (!kind_i || flush_ok);
  assign c_use       = (!kind_i && restart_pre) ? '0 : col_q;
  assign r_use       = (!kind_i && restart_pre) ? '0 : row_q;
  assign c_inc       = WW'(c_use) + WW'(1);
  assign wrap        = c_inc >= width_q;
  assign c_pos       = c_use != '0;
  assign cr          = c_pos ? r_use - RW'(1) : r_use - RW'(2);
  assign cc          = c_pos ? c_use - CW'(1) : CW'(width_q - WW'(1));
  assign pend_dec    = pend_q - PW'(1);

  always_comb begin
    s1_d.emit      = c_pos ? (r_use >= RW'(1)) : (r_use >= RW'(2));
    s1_d.clr       = win_clr_q || (!kind_i && restart_pre);
    s1_d.pix       = !kind_i && pixel_in_i;
    s1_d.top_out   = cr == '0;
    s1_d.bot_out   = (cr + RW'(1)) >= RW'(height_q);
    s1_d.left_out  = cc == '0;
    s1_d.right_out = (WW'(cc) + WW'(1)) >= width_q;
    s1_d.frame_end = (cr + RW'(1) == RW'(height_q)) && (WW'(cc) + WW'(1) == width_q);
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    pend_d    = pend_q;
    win_clr_d = win_clr_q;
    if (cfg_hit) begin
      col_d     = '0;
      row_d     = '0;
      pend_d    = '0;
      win_clr_d = 1'b1;
    end else if (do_proc) begin
      col_d     = wrap ? '0 : CW'(c_inc);
      row_d     = wrap ? r_use + RW'(1) : r_use;
      win_clr_d = 1'b0;
      if (!kind_i) begin
        pend_d = (row_d >= RW'(height_q)) ? PW'(width_q) + PW'(1) : '0;
      end else begin
        pend_d = pend_dec;
        if (pend_dec == '0) begin
          col_d     = '0;
          row_d     = '0;
          win_clr_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pend_q     <= '0;
      win_clr_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      win_q      <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      pend_q     <= pend_d;
      win_clr_q  <= win_clr_d;
      s1_valid_q <= do_proc;
      fwd_q      <= fwd_d;
      if (s1_valid_q) begin
        win_q <= win_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_proc) begin
      s1_q       <= s1_d;
      s1_addr_q  <= c_use;
      fwd_data_q <= {s1_q.pix, mid};
    end
  end

  // line memory: bit 1 holds the previous row, bit 0 the row before it
  assign fwd_d = do_proc && s1_valid_q && (c_use == s1_addr_q);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem_q[s1_addr_q] <= {s1_q.pix, mid};
    end
    if (do_proc) begin
      rd_q <= line_mem_q[c_use];
    end
  end

  // window and hit-or-miss masks
  assign rd_eff = fwd_q ? fwd_data_q : rd_q;
  assign mid    = rd_eff[1];
  assign top    = rd_eff[0];
  assign win_nx = {s1_q.pix, mid, top, (s1_q.clr ? 6'd0 : win_q[8:3])};

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      nb[k] = win_nx[k] &&
              !((k % 3 == 0) && s1_q.top_out) &&
              !((k % 3 == 2) && s1_q.bot_out) &&
              !((k / 3 == 0) && s1_q.left_out) &&
              !((k / 3 == 2) && s1_q.right_out);
    end
  end

  assign m1 = nb[0] | nb[3] | nb[6] | nb[1] | nb[7];
  assign m2 = nb[0] | nb[1] | nb[2] | nb[3] | nb[5];
  assign m3 = nb[2] | nb[5] | nb[8] | nb[1] | nb[7];
  assign m4 = nb[6] | nb[7] | nb[8] | nb[3] | nb[5];

  assign res.endpoint  = nb[4] && (!m1 || !m2 || !m3 || !m4);
  assign res.center_fg = nb[4];
  assign res.frame_end = s1_q.frame_end;
  assign push          = s1_valid_q && s1_q.emit;

  // result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= res;
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign endpoint_o  = fifo_q[rp_q].endpoint;
  assign center_fg_o = fifo_q[rp_q].center_fg;
  assign frame_end_o = fifo_q[rp_q].frame_end;

  `SED_ASSERT_IMP(a_col_range, 1'b1, WW'(col_q) < width_q, "column beyond image width")
  `SED_ASSERT_IMP(a_pend_row, pend_q != '0, row_q >= RW'(height_q), "drain outside frame end")
  `SED_ASSERT_IMP(a_queue_room, s1_valid_q, cnt_q != 2'd2, "result queue without room")
  `SED_ASSERT_IMP(a_fwd_item, fwd_q, s1_valid_q, "forward without item in flight")
  `SED_ASSERT_NXT(a_cfg_restart, cfg_hit, col_q == '0 && row_q == '0 && pend_q == '0,
    "register write did not restart frame")

endmodule

// ===== tb/tb_skeleton_endpoint_detect_top.sv =====
`timescale 1ns / 1ps

module tb_skeleton_endpoint_detect_top;
  import sed_pkg::*;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = CfgIdxW'(3);
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned RandomItems  = 350;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_q    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_q   = '0;
  logic [CfgDataW-1:0] cfg_data_q  = '0;
  logic                in_valid_q  = 1'b0;
  logic                kind_q      = 1'b0;
  logic                pixel_q     = 1'b0;
  logic                out_ready_q = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                endpoint_o;
  logic                center_fg_o;
  logic                frame_end_o;

  skeleton_endpoint_detect_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_q),
    .cfg_index_i (cfg_idx_q),
    .cfg_data_i  (cfg_data_q),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_q),
    .pixel_in_i  (pixel_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_q),
    .endpoint_o  (endpoint_o),
    .center_fg_o (center_fg_o),
    .frame_end_o (frame_end_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Detector state mirrored for prediction
  bit                  line_mem_a [MaxWidthDef];
  bit                  line_mem_b [MaxWidthDef];
  bit [8:0]            win_bits;
  int unsigned         col_cnt;
  int unsigned         row_cnt;
  int unsigned         drain_cnt;
  bit [RegWidthW-1:0]  width_reg  = RegWidthW'(WidthRst);
  bit [RegHeightW-1:0] height_reg = RegHeightW'(HeightRst);

  result_t     flags_due_q [$];
  result_t     want;
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned burst_left;
  int unsigned hold_cnt;
  int unsigned idle_cycles;

  function automatic void restart_frame();
    win_bits  = '0;
    col_cnt   = 0;
    row_cnt   = 0;
    drain_cnt = 0;
  endfunction

  function automatic logic window_cell(int unsigned row, int unsigned col, int unsigned cr,
                                       int unsigned cc, int unsigned w, int unsigned h);
    if (row == 0 && cr == 0) return 1'b0;
    if (row == 2 && cr + 1 >= h) return 1'b0;
    if (col == 0 && cc == 0) return 1'b0;
    if (col == 2 && cc + 1 >= w) return 1'b0;
    return win_bits[col * 3 + row];
  endfunction

  function automatic void shift_and_classify(logic pix, int unsigned w, int unsigned h);
    int unsigned r, c, cr, cc, slot;
    logic        top, mid, m1, m2, m3, m4;
    logic [2:0][2:0] nb;
    result_t     res;
    r    = row_cnt;
    c    = col_cnt;
    slot = (c >= MaxWidthDef) ? 0 : c;
    top  = line_mem_b[slot];
    mid  = line_mem_a[slot];
    line_mem_b[slot] = mid;
    line_mem_a[slot] = pix;
    win_bits = {pix, mid, top, win_bits[8:3]};
    col_cnt  = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end
    if (c >= 1) begin
      if (r < 1) return;
      cr = r - 1;
      cc = c - 1;
    end else begin
      if (r < 2) return;
      cr = r - 2;
      cc = w - 1;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        nb[i][j] = window_cell(i, j, cr, cc, w, h);
    m1 = nb[0][0] | nb[0][1] | nb[0][2] | nb[1][0] | nb[1][2];
    m2 = nb[0][0] | nb[1][0] | nb[2][0] | nb[0][1] | nb[2][1];
    m3 = nb[2][0] | nb[2][1] | nb[2][2] | nb[1][0] | nb[1][2];
    m4 = nb[0][2] | nb[1][2] | nb[2][2] | nb[0][1] | nb[2][1];
    res.endpoint  = nb[1][1] & (!m1 | !m2 | !m3 | !m4);
    res.center_fg = nb[1][1];
    res.frame_end = (cr + 1 == h) && (cc + 1 == w);
    flags_due_q.push_back(res);
  endfunction

  function automatic void predict_endpoints(logic kind, logic pix);
    int unsigned w, h;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MaxWidthDef) w = MaxWidthDef;
    h = (height_reg == 0) ? 1 : height_reg;
    if (col_cnt >= w) restart_frame();
    if (kind == KIND_PIXEL) begin
      if (row_cnt >= h) restart_frame();
      shift_and_classify(pix, w, h);
      if (row_cnt >= h) drain_cnt = w + 1;
    end else if (row_cnt >= h && drain_cnt != 0) begin
      shift_and_classify(1'b0, w, h);
      drain_cnt--;
      if (drain_cnt == 0) restart_frame();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: result %0d: %s", $time, results_seen, what);
    err_cnt++;
  endtask

  task automatic send_item(input logic kind, input logic pix);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(9) < 4) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid_q <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(40, 1);
    end
    burst_left--;
    in_valid_q <= 1'b1;
    kind_q     <= kind;
    pixel_q    <= pix;
    do @(posedge clk_i); while (!in_ready_o);
    predict_endpoints(kind, pix);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_q <= 1'b0;
    burst_left = 0;
    while (flags_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    wait_idle();
    cfg_we_q   <= 1'b1;
    cfg_idx_q  <= idx;
    cfg_data_q <= val;
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_reg = val[RegWidthW-1:0];
      restart_frame();
    end else if (idx == CFG_IMAGE_HEIGHT) begin
      height_reg = val[RegHeightW-1:0];
      restart_frame();
    end
  endtask

  task automatic set_size(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // pixels at the given foreground percentage, with stray flushes when noisy, then n_flush flushes
  task automatic send_frame(input int unsigned n_pix, input int unsigned dens,
                            input int unsigned n_flush, input bit noisy);
    for (int unsigned i = 0; i < n_pix; i++) begin
      if (noisy && $urandom_range(15) == 0) send_item(KIND_FLUSH, 1'($urandom_range(1)));
      send_item(KIND_PIXEL, $urandom_range(99) < dens);
    end
    for (int unsigned i = 0; i < n_flush; i++) send_item(KIND_FLUSH, 1'($urandom_range(1)));
  endtask

  task automatic send_pattern(input logic [15:0] bits, input int unsigned n_pix,
                              input int unsigned n_flush);
    for (int unsigned i = 0; i < n_pix; i++) send_item(KIND_PIXEL, bits[i]);
    for (int unsigned i = 0; i < n_flush; i++) send_item(KIND_FLUSH, 1'b0);
  endtask

  task automatic test_reset_size();
    send_frame(650, 40, 0, 0);
  endtask

  task automatic test_basic_patterns();
    set_size(3, 3);
    send_pattern(16'h0010, 9, 4);
    send_pattern(16'h01FF, 9, 4);
    send_pattern(16'h0038, 9, 4);
  endtask

  task automatic test_flush_outside_drain();
    set_size(4, 2);
    send_item(KIND_FLUSH, 1'b1);
    send_frame(3, 50, 0, 0);
    send_item(KIND_FLUSH, 1'b0);
    send_frame(5, 50, 5, 0);
    send_item(KIND_FLUSH, 1'b1);
  endtask

  task automatic test_pixel_during_drain();
    set_size(3, 2);
    send_frame(6, 60, 2, 0);
    send_frame(6, 60, 4, 0);
  endtask

  task automatic test_single_row();
    set_size(5, 1);
    send_pattern(16'h000D, 5, 6);
  endtask

  task automatic test_zero_sizes();
    set_size(0, 0);
    send_pattern(16'h0001, 1, 2);
    send_pattern(16'h0000, 1, 2);
  endtask

  task automatic test_large_sizes();
    set_size(13'h0FFF, 2);
    send_frame(60, 5, 2, 0);
    set_size(13'h1800, 1);
    send_frame(30, 5, 2, 0);
    set_size(1, 13'h1FFF);
    send_frame(40, 30, 2, 0);
  endtask

  task automatic test_mid_frame_write();
    set_size(6, 4);
    send_frame(10, 50, 0, 0);
    write_reg(CFG_SPARE, CfgDataW'($urandom));
    send_frame(14, 50, 7, 0);
    send_frame(10, 50, 0, 0);
    write_reg(CFG_IMAGE_HEIGHT, 4);
    send_frame(24, 50, 7, 0);
  endtask

  task automatic test_random_frames();
    int unsigned goal, w, h, dens, frames_left, pick;
    goal        = items_sent + RandomItems;
    frames_left = 0;
    w           = 1;
    h           = 1;
    while (items_sent < goal) begin
      if (frames_left == 0) begin
        pick = $urandom_range(19);
        if (pick == 0) begin
          w = $urandom_range(100, 41);
          h = $urandom_range(2, 1);
        end else if (pick < 6) begin
          w = $urandom_range(40, 11);
          h = $urandom_range(6, 1);
        end else begin
          w = $urandom_range(10, 1);
          h = $urandom_range(8, 1);
        end
        set_size(CfgDataW'(w) | CfgDataW'($urandom_range(1) << 12), CfgDataW'(h));
        frames_left = $urandom_range(4, 1);
      end
      dens = $urandom_range(3) * 25 + 10;
      pick = $urandom_range(9);
      if (pick < 7) begin
        send_frame(w * h, dens, w + 1, 0);
      end else if (pick == 7) begin
        send_frame(w * h, dens, $urandom_range(w), 1);
      end else if (pick == 8) begin
        send_frame($urandom_range(w * h - 1), dens, 0, 0);
        frames_left = 1;
      end else begin
        send_frame(w * h, dens, w + 1, 1);
      end
      frames_left--;
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      case ($urandom_range(3))
        0: begin
          out_ready_q <= 1'b1;
          hold_cnt    <= $urandom_range(60, 10);
        end
        1: begin
          out_ready_q <= 1'b0;
          hold_cnt    <= $urandom_range(20, 1);
        end
        default: begin
          out_ready_q <= 1'($urandom_range(1));
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_q) begin
      if (flags_due_q.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        want = flags_due_q.pop_front();
        if (endpoint_o !== want.endpoint)
          report_mismatch($sformatf("endpoint %b, want %b", endpoint_o, want.endpoint));
        if (center_fg_o !== want.center_fg)
          report_mismatch($sformatf("center_fg %b, want %b", center_fg_o, want.center_fg));
        if (frame_end_o !== want.frame_end)
          report_mismatch($sformatf("frame_end %b, want %b", frame_end_o, want.frame_end));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_q && in_ready_o) || (out_valid_o && out_ready_q)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("tb_skeleton_endpoint_detect_top: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_basic_patterns();
    test_flush_outside_drain();
    test_pixel_during_drain();
    test_single_row();
    test_zero_sizes();
    test_mid_frame_write();
    test_large_sizes();
    test_random_frames();
    wait_idle();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_skeleton_endpoint_detect_top: PASS");
    end else begin
      $display("tb_skeleton_endpoint_detect_top: FAIL");
    end
    $finish;
  end

endmodule
